// File: hdl/rocd_pkg.sv
// Shared types, constants and helpers for the raw OPL capture stream decoder.
// No dependencies; the result queue and the decoder import this package.
package rocd_pkg;

   localparam int HEADER_BYTES = 26;
   localparam int MAP_ENTRIES  = 128;
   localparam int MAP_AW       = $clog2(MAP_ENTRIES);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   // Result kinds on the response channel.
   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   // Decoder phase, one-hot.
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_MAP    = 5'b00010,
      PH_CODE   = 5'b00100,
      PH_VALUE  = 5'b01000,
      PH_TAIL   = 5'b10000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] time_ms;
      logic [7:0]  reg_index;
      logic [7:0]  reg_value;
      logic [31:0] total_pairs;
      logic [31:0] total_writes;
      logic        last_of_run;
   } rsp_item_type;

   // Up to two results per accepted byte; a lone result always uses slot 0.
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   // File signature "DBRAWOPL".
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'h44;
         3'd1: val = 8'h42;
         3'd2: val = 8'h52;
         3'd3: val = 8'h41;
         3'd4: val = 8'h57;
         3'd5: val = 8'h4F;
         3'd6: val = 8'h50;
         3'd7: val = 8'h4C;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// File: hdl/rocd_req_if.sv
// Byte input channel of the capture stream decoder: valid/ready plus payload.
// Stand-alone interface, no package dependency.
interface rocd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// File: hdl/rocd_rsp_if.sv
// Result channel of the capture stream decoder: valid/ready plus payload.
// Stand-alone interface, no package dependency.
interface rocd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] time_ms;
   logic [7:0]  reg_index;
   logic [7:0]  reg_value;
   logic [31:0] total_pairs;
   logic [31:0] total_writes;
   logic        last_of_run;

   modport source (output valid, output kind, output time_ms, output reg_index,
                   output reg_value, output total_pairs, output total_writes,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input time_ms, input reg_index,
                   input reg_value, input total_pairs, input total_writes,
                   input last_of_run, output ready);
endinterface

// File: hdl/rocd_rsp_queue.sv
// Small result queue that takes up to two results per cycle and drives the
// response channel. Depends on rocd_pkg and rocd_rsp_if.
module rocd_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  rocd_pkg::push_type push,
   output logic               can_take2,
   rocd_rsp_if.source         rsp_bus
);
   import rocd_pkg::*;

   rsp_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   logic                      pop;
   logic [QUEUE_AW:0]         n_push;
   rsp_item_type              head;

   assign pop       = rsp_bus.valid && rsp_bus.ready;
   assign n_push    = (QUEUE_AW+1)'(push.first_valid) + (QUEUE_AW+1)'(push.second_valid);
   assign can_take2 = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[QUEUE_AW-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + n_push - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   assign head = entry_ff[rd_ptr_ff];

   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.kind         = head.kind;
   assign rsp_bus.time_ms      = head.time_ms;
   assign rsp_bus.reg_index    = head.reg_index;
   assign rsp_bus.reg_value    = head.reg_value;
   assign rsp_bus.total_pairs  = head.total_pairs;
   assign rsp_bus.total_writes = head.total_writes;
   assign rsp_bus.last_of_run  = head.last_of_run;

endmodule

// File: hdl/raw_opl_capture_stream_decoder.sv
// Raw OPL capture stream decoder (version 2 layout).
// Depends on rocd_pkg, rocd_req_if, rocd_rsp_if and rocd_rsp_queue.
//
// Takes the capture file one byte per transfer and can accept a byte every
// clock cycle; the only thing that slows it is the result queue: req ready
// drops while the four-entry queue holds three or more results, i.e. when the
// consumer stalls. The 26-byte header is checked (signature, version 2, zero
// hardware/format/compression), the code map goes into a 128x8 synchronous
// RAM, then code/value pairs are walked. A code byte launches the map read;
// the registered read data is used when the value byte arrives, so the lookup
// never holds up the byte stream. Register writes are streamed as decoded; the
// byte flagged end_of_file adds an accept or reject verdict (last_of_run set
// on the final result of that byte). On reject, the consumer discards the
// writes already streamed for that file. No clearing pass after reset.
module raw_opl_capture_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   rocd_req_if.sink   req_bus,
   rocd_rsp_if.source rsp_bus
);
   import rocd_pkg::*;

   // ---- per-file state ----
   phase_type   phase_ff, phase_in;
   logic [8:0]  pos_ff, pos_in;
   logic [31:0] pairs_ff, pairs_in;          // declared pair count
   logic [31:0] duration_ff, duration_in;    // declared duration
   logic [7:0]  short_code_ff, short_code_in;
   logic [7:0]  long_code_ff, long_code_in;
   logic [7:0]  map_len_ff, map_len_in;
   logic [31:0] left_ff, left_in;            // pairs still to walk
   logic [7:0]  pending_ff, pending_in;      // code byte of current pair
   logic [32:0] elapsed_ff, elapsed_in;      // saturating at all ones
   logic [31:0] writes_ff, writes_in;
   logic        error_ff, error_in;

   // ---- code map RAM ----
   logic [7:0]  map_mem [MAP_ENTRIES];
   logic [7:0]  map_rd_ff;
   logic        map_we;
   logic        map_re;

   // ---- datapath helpers ----
   logic        req_fire;
   logic [7:0]  b;
   logic        eof;
   logic        can_take2;
   logic        is_short;
   logic        is_long;
   logic [16:0] delta;
   logic [33:0] elapsed_sum;
   logic [31:0] left_dec;
   logic        emit_write;
   logic        accept_ok;
   rsp_item_type write_item;
   rsp_item_type verdict_item;
   push_type    push;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = can_take2;
   assign b             = req_bus.data_byte;
   assign eof           = req_bus.end_of_file;

   // Pair decode: short code wins when both delay codes are equal.
   assign is_short    = (pending_ff == short_code_ff);
   assign is_long     = (pending_ff == long_code_ff);
   assign delta       = is_short ? (17'({9'd0, b}) + 17'd1)
                                 : ((17'({9'd0, b}) + 17'd1) << 8);
   assign elapsed_sum = {1'b0, elapsed_ff} + {17'd0, delta};
   assign left_dec    = left_ff - 32'd1;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      pairs_in      = pairs_ff;
      duration_in   = duration_ff;
      short_code_in = short_code_ff;
      long_code_in  = long_code_ff;
      map_len_in    = map_len_ff;
      left_in       = left_ff;
      pending_in    = pending_ff;
      elapsed_in    = elapsed_ff;
      writes_in     = writes_ff;
      error_in      = error_ff;
      map_we        = 1'b0;
      map_re        = 1'b0;
      emit_write    = 1'b0;

      if (req_fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               case (pos_ff) inside
                  [9'd0:9'd7]: begin
                     if (b != sig_byte(pos_ff[2:0])) error_in = 1'b1;
                  end
                  9'd8: begin
                     if (b != 8'd2) error_in = 1'b1;
                  end
                  [9'd9:9'd11], [9'd20:9'd22]: begin
                     if (b != 8'd0) error_in = 1'b1;
                  end
                  [9'd12:9'd15]: pairs_in[8*pos_ff[1:0] +: 8] = b;
                  [9'd16:9'd19]: duration_in[8*pos_ff[1:0] +: 8] = b;
                  9'd23: short_code_in = b;
                  9'd24: long_code_in = b;
                  default: map_len_in = b;
               endcase
               pos_in = pos_ff + 9'd1;
               if (pos_ff == 9'(HEADER_BYTES - 1)) begin
                  pos_in = '0;
                  if (error_in) begin
                     phase_in = PH_TAIL;
                  end else if (map_len_in != 8'd0) begin
                     phase_in = PH_MAP;
                  end else begin
                     left_in  = pairs_ff;
                     phase_in = (pairs_ff != '0) ? PH_CODE : PH_TAIL;
                  end
               end
            end
            PH_MAP: begin
               // entries past the RAM depth are read and dropped
               map_we = (pos_ff < 9'(MAP_ENTRIES));
               pos_in = pos_ff + 9'd1;
               if (pos_in >= {1'b0, map_len_ff}) begin
                  pos_in   = '0;
                  left_in  = pairs_ff;
                  phase_in = (pairs_ff != '0) ? PH_CODE : PH_TAIL;
               end
            end
            PH_CODE: begin
               pending_in = b;
               phase_in   = PH_VALUE;
               map_re     = 1'b1;
               if (b != short_code_ff && b != long_code_ff) begin
                  // bad code, code past the map, or write after 32-bit time
                  if (b[7] || b >= map_len_ff || {1'b0, b} >= 9'(MAP_ENTRIES) ||
                      elapsed_ff[32]) begin
                     error_in = 1'b1;
                     phase_in = PH_TAIL;
                  end
               end
            end
            PH_VALUE: begin
               if (is_short || is_long) begin
                  elapsed_in = elapsed_sum[33] ? '1 : elapsed_sum[32:0];
               end else begin
                  emit_write = 1'b1;
                  writes_in  = writes_ff + 32'd1;
               end
               left_in  = left_dec;
               phase_in = (left_dec != '0) ? PH_CODE : PH_TAIL;
            end
            PH_TAIL: phase_in = PH_TAIL;
            default: phase_in = PH_TAIL;
         endcase
      end
   end

   // Verdict uses the state as left by this byte.
   assign accept_ok = !error_in && (phase_in == PH_TAIL) &&
                      (elapsed_in == {1'b0, duration_in});

   always_comb begin
      write_item              = '0;
      write_item.kind         = KIND_WRITE;
      write_item.time_ms      = elapsed_ff[31:0];
      write_item.reg_index    = map_rd_ff;
      write_item.reg_value    = b;
      write_item.last_of_run  = !eof;

      verdict_item             = '0;
      verdict_item.last_of_run = 1'b1;
      if (accept_ok) begin
         verdict_item.kind         = KIND_ACCEPT;
         verdict_item.time_ms      = duration_in;
         verdict_item.total_pairs  = pairs_in;
         verdict_item.total_writes = writes_in;
      end else begin
         verdict_item.kind = KIND_REJECT;
      end

      push.first_valid  = req_fire && (emit_write || eof);
      push.second_valid = req_fire && emit_write && eof;
      push.first        = emit_write ? write_item : verdict_item;
      push.second       = verdict_item;
   end

   always_ff @(posedge clock) begin
      if (reset || (req_fire && eof)) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         pairs_ff      <= '0;
         duration_ff   <= '0;
         short_code_ff <= '0;
         long_code_ff  <= '0;
         map_len_ff    <= '0;
         left_ff       <= '0;
         pending_ff    <= '0;
         elapsed_ff    <= '0;
         writes_ff     <= '0;
         error_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         pairs_ff      <= pairs_in;
         duration_ff   <= duration_in;
         short_code_ff <= short_code_in;
         long_code_ff  <= long_code_in;
         map_len_ff    <= map_len_in;
         left_ff       <= left_in;
         pending_ff    <= pending_in;
         elapsed_ff    <= elapsed_in;
         writes_ff     <= writes_in;
         error_ff      <= error_in;
      end
   end

   // Map RAM: written during the map phase, read on each code byte.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[pos_ff[MAP_AW-1:0]] <= b;
      end
      if (map_re) begin
         map_rd_ff <= map_mem[b[MAP_AW-1:0]];
      end
   end

   rocd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .can_take2 (can_take2),
      .rsp_bus   (rsp_bus)
   );

`ifndef ASSERT_OFF
   // A byte flagged end_of_file always leaves the decoder at a fresh header.
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && eof |=> phase_ff == PH_HEADER && pos_ff == '0 && !error_ff)
      else $error("decoder not restarted after end of file");

   // The write count only moves on a value byte or a file restart.
   a_writes_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (phase_ff == PH_VALUE || eof)) |=> $stable(writes_ff))
      else $error("write count changed without a value byte");

   // Back-pressure only while results are waiting.
   a_stall_has_results: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("input stalled with empty result queue");
`endif

endmodule
